>>> sv/lftg_pkg.sv
// Package for the LCD frame timing generator: register indices, widths and config bundle.
`default_nettype none

package lftg_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned COLOUR_W   = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H_PORCH_BEFORE = 3'd0,
        CFG_H_ACTIVE       = 3'd1,
        CFG_H_PORCH_AFTER  = 3'd2,
        CFG_V_SYNC_LINES   = 3'd3,
        CFG_V_PORCH_BEFORE = 3'd4,
        CFG_V_ACTIVE       = 3'd5,
        CFG_V_PORCH_AFTER  = 3'd6,
        CFG_FILL_COLOUR    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]          h_porch_before;
        logic [10:0]         h_active;
        logic [9:0]          h_porch_after;
        logic [5:0]          v_sync_lines;
        logic [7:0]          v_porch_before;
        logic [10:0]         v_active;
        logic [7:0]          v_porch_after;
        logic [COLOUR_W-1:0] fill_colour;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        h_porch_before: 10'd160,
        h_active:       11'd1024,
        h_porch_after:  10'd160,
        v_sync_lines:   6'd2,
        v_porch_before: 8'd8,
        v_active:       11'd600,
        v_porch_after:  8'd10,
        fill_colour:    24'd255
    };

endpackage

`default_nettype wire

>>> sv/lcd_frame_timing_generator.sv
// Top level of the LCD frame timing generator: position counters and output word register.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+--------------------------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_tick
//   out     | from block| o_out_valid / i_out_stall  | hsync_n, vsync_n, data_enable, rgb,
//           |           |                            | frame_end
//   cfg     | to block  | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One input word per clock while o_in_stall is low; its result word appears from the output register in the next cycle.
// The output register is the only stage, so words flow back to back while it drains.
// o_in_stall is high only while a result waits and the output side is stalled.
// Synchronous active-low reset clears counters and valid and loads the config defaults; the result word is not reset.
`default_nettype none

module lcd_frame_timing_generator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lftg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lftg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_tick,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_hsync_n,
    output logic                                 o_vsync_n,
    output logic                                 o_data_enable,
    output logic [7:0]                           o_red,
    output logic [7:0]                           o_green,
    output logic [7:0]                           o_blue,
    output logic                                 o_frame_end
);
    import lftg_pkg::*;

    t_cfg cfg;

    lftg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic [POS_W-1:0] r_pix;
    logic [POS_W-1:0] r_line;
    logic [POS_W-1:0] n_pix;
    logic [POS_W-1:0] n_line;

    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_hsync_n;
    logic             r_vsync_n;
    logic             r_de;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic             r_frame_end;

    logic             accept;
    logic [POS_W-1:0] act_h_lo;
    logic [POS_W-1:0] act_h_hi;
    logic [POS_W-1:0] line_len;
    logic [POS_W-1:0] act_v_lo;
    logic [POS_W-1:0] act_v_hi;
    logic [POS_W-1:0] frame_lines;
    logic [POS_W:0]   pix_inc;
    logic [POS_W:0]   line_inc;
    logic             h_act;
    logic             v_act;
    logic             de;
    logic             last_pix;
    logic             last_line;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // region boundaries
    always_comb begin
        act_h_lo    = POS_W'(cfg.h_porch_before) + POS_W'(1);
        act_h_hi    = act_h_lo + POS_W'(cfg.h_active);
        line_len    = act_h_hi + POS_W'(cfg.h_porch_after);
        act_v_lo    = POS_W'(cfg.v_sync_lines) + POS_W'(cfg.v_porch_before);
        act_v_hi    = act_v_lo + POS_W'(cfg.v_active);
        frame_lines = act_v_hi + POS_W'(cfg.v_porch_after);
    end

    always_comb begin
        pix_inc   = {1'b0, r_pix} + (POS_W+1)'(1);
        line_inc  = {1'b0, r_line} + (POS_W+1)'(1);
        h_act     = (r_pix >= act_h_lo) && (r_pix < act_h_hi);
        v_act     = (r_line >= act_v_lo) && (r_line < act_v_hi);
        de        = h_act & v_act;
        last_pix  = pix_inc >= {1'b0, line_len};
        last_line = line_inc >= {1'b0, frame_lines};
    end

    always_comb begin
        n_pix  = r_pix;
        n_line = r_line;
        if (accept && i_tick) begin
            if (last_pix) begin
                n_pix = '0;
                if (last_line) begin
                    n_line = '0;
                end else begin
                    n_line = line_inc[POS_W-1:0];
                end
            end else begin
                n_pix = pix_inc[POS_W-1:0];
            end
        end
    end

    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix       <= '0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pix       <= n_pix;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
    end

    // result word, loaded on acceptance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hsync_n   <= (r_pix != '0);
            r_vsync_n   <= ~(r_line < POS_W'(cfg.v_sync_lines));
            r_de        <= de;
            r_red       <= de ? cfg.fill_colour[7:0]   : 8'd0;
            r_green     <= de ? cfg.fill_colour[15:8]  : 8'd0;
            r_blue      <= de ? cfg.fill_colour[23:16] : 8'd0;
            r_frame_end <= last_pix & last_line;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hsync_n     = r_hsync_n;
    assign o_vsync_n     = r_vsync_n;
    assign o_data_enable = r_de;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_frame_end   = r_frame_end;

endmodule

`default_nettype wire

>>> sv/lftg_cfg.sv
// Configuration register bank for the LCD frame timing generator.
`default_nettype none

module lftg_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lftg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lftg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lftg_pkg::t_cfg                       o_cfg
);
    import lftg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_H_PORCH_BEFORE: n_cfg.h_porch_before = i_cfg_data[9:0];
                CFG_H_ACTIVE:       n_cfg.h_active       = i_cfg_data[10:0];
                CFG_H_PORCH_AFTER:  n_cfg.h_porch_after  = i_cfg_data[9:0];
                CFG_V_SYNC_LINES:   n_cfg.v_sync_lines   = i_cfg_data[5:0];
                CFG_V_PORCH_BEFORE: n_cfg.v_porch_before = i_cfg_data[7:0];
                CFG_V_ACTIVE:       n_cfg.v_active       = i_cfg_data[10:0];
                CFG_V_PORCH_AFTER:  n_cfg.v_porch_after  = i_cfg_data[7:0];
                CFG_FILL_COLOUR:    n_cfg.fill_colour    = i_cfg_data[COLOUR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/lftg_chk.sv
// Port-level checker for the LCD frame timing generator, bound to the top level.
`default_nettype none

module lftg_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_hsync_n,
    input wire logic       o_vsync_n,
    input wire logic       o_data_enable,
    input wire logic [7:0] o_red,
    input wire logic [7:0] o_green,
    input wire logic [7:0] o_blue,
    input wire logic       o_frame_end
);

    // blanked word carries black
    a_blank_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_data_enable) |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("colour not zero while data enable low");

    // the sync clock never lies in the active region
    a_sync_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hsync_n) |-> !o_data_enable)
        else $error("data enable high on hsync clock");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_hsync_n) && $stable(o_vsync_n)
            && $stable(o_data_enable) && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_frame_end)))
        else $error("output word changed while stalled");

endmodule

bind lcd_frame_timing_generator lftg_chk u_lftg_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_hsync_n     (o_hsync_n),
    .o_vsync_n     (o_vsync_n),
    .o_data_enable (o_data_enable),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_frame_end   (o_frame_end)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the LCD frame timing generator: raster predictor and word scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import lftg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 50;

    typedef struct packed {
        logic       hsync_n;
        logic       vsync_n;
        logic       data_enable;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_pixel_word;

    typedef enum logic {ROW_WRITE, ROW_TICK} t_row_kind;
    typedef enum int {SHAPE_SMALL, SHAPE_WIDE, SHAPE_TALL} t_shape;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [23:0] data;
        logic        tick;
        logic        typed;
        t_pixel_word word;
    } t_stim_row;

    localparam t_pixel_word NO_WORD         = '0;
    localparam t_pixel_word SYNC_CORNER     = {1'b0, 1'b0, 1'b0, 24'h0, 1'b0};
    localparam t_pixel_word HSYNC_RELEASED  = {1'b1, 1'b0, 1'b0, 24'h0, 1'b0};
    localparam t_pixel_word DEGENERATE_LINE = {1'b0, 1'b1, 1'b0, 24'h0, 1'b1};

    // reset values first, then a one-pixel line/frame, then a tiny raster, then extremes
    t_stim_row directed_rows [42] = '{
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b0, 1'b1, SYNC_CORNER},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b1, SYNC_CORNER},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b1, HSYNC_RELEASED},
        '{ROW_WRITE, CFG_H_PORCH_BEFORE, 24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_H_ACTIVE,       24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_H_PORCH_AFTER,  24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_SYNC_LINES,   24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_PORCH_BEFORE, 24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_ACTIVE,       24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_PORCH_AFTER,  24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_FILL_COLOUR,    24'hFFFFFF, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b1, DEGENERATE_LINE},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b0, 1'b1, DEGENERATE_LINE},
        '{ROW_WRITE, CFG_H_PORCH_BEFORE, 24'd1,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_H_ACTIVE,       24'd2,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_H_PORCH_AFTER,  24'd1,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_SYNC_LINES,   24'd1,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_PORCH_BEFORE, 24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_ACTIVE,       24'd1,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_PORCH_AFTER,  24'd0,      1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_FILL_COLOUR,    24'h5AC3A5, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b0, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_H_PORCH_BEFORE, 24'd1023,   1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_H_ACTIVE,       24'd2047,   1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_H_PORCH_AFTER,  24'd1023,   1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_SYNC_LINES,   24'd63,     1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_PORCH_BEFORE, 24'd255,    1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_ACTIVE,       24'd2047,   1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_V_PORCH_AFTER,  24'd255,    1'b0, 1'b0, NO_WORD},
        '{ROW_WRITE, CFG_FILL_COLOUR,    24'h000000, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD},
        '{ROW_TICK,  CFG_H_PORCH_BEFORE, 24'h0,      1'b1, 1'b0, NO_WORD}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_tick      = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_hsync_n;
    logic                  o_vsync_n;
    logic                  o_data_enable;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic                  o_frame_end;

    // word-side sidecar: a directed row may pin its expected word
    logic        typed_valid = 1'b0;
    t_pixel_word typed_word  = '0;

    t_cfg              timing_cfg = CFG_RESET;
    logic [POS_W-1:0]  pix_pos    = '0;
    logic [POS_W-1:0]  line_pos   = '0;
    t_pixel_word       pending_pixels [$];
    int                mismatches     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    logic              hold_req       = 1'b0;
    int                hold_left      = 0;
    int                cycle_count    = 0;

    lcd_frame_timing_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_tick        (i_tick),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hsync_n     (o_hsync_n),
        .o_vsync_n     (o_vsync_n),
        .o_data_enable (o_data_enable),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_frame_end   (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_pixel_word advance_raster(input logic tick);
        int unsigned h_lo, h_hi, line_len, v_lo, v_hi, frame_len;
        logic        de, last_pix, last_line;
        t_pixel_word w;
        h_lo      = 32'(timing_cfg.h_porch_before) + 1;
        h_hi      = h_lo + 32'(timing_cfg.h_active);
        line_len  = h_hi + 32'(timing_cfg.h_porch_after);
        v_lo      = 32'(timing_cfg.v_sync_lines) + 32'(timing_cfg.v_porch_before);
        v_hi      = v_lo + 32'(timing_cfg.v_active);
        frame_len = v_hi + 32'(timing_cfg.v_porch_after);
        de        = (32'(pix_pos) >= h_lo) && (32'(pix_pos) < h_hi)
                 && (32'(line_pos) >= v_lo) && (32'(line_pos) < v_hi);
        last_pix  = 32'(pix_pos) + 1 >= line_len;
        last_line = 32'(line_pos) + 1 >= frame_len;
        w.hsync_n     = (pix_pos != '0);
        w.vsync_n     = !(32'(line_pos) < 32'(timing_cfg.v_sync_lines));
        w.data_enable = de;
        w.red         = de ? timing_cfg.fill_colour[7:0]   : 8'h00;
        w.green       = de ? timing_cfg.fill_colour[15:8]  : 8'h00;
        w.blue        = de ? timing_cfg.fill_colour[23:16] : 8'h00;
        w.frame_end   = last_pix && last_line;
        if (tick) begin
            if (last_pix) begin
                pix_pos  = '0;
                line_pos = last_line ? '0 : line_pos + 1'b1;
            end else begin
                pix_pos = pix_pos + 1'b1;
            end
        end
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_pixel_word got;
        t_pixel_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_hsync_n, o_vsync_n, o_data_enable, o_red, o_green, o_blue, o_frame_end};
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual 0x%0h", $time, got);
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("hsync_n",     want.hsync_n,     got.hsync_n);
                    check_field("vsync_n",     want.vsync_n,     got.vsync_n);
                    check_field("data_enable", want.data_enable, got.data_enable);
                    check_field("red",         want.red,         got.red);
                    check_field("green",       want.green,       got.green);
                    check_field("blue",        want.blue,        got.blue);
                    check_field("frame_end",   want.frame_end,   got.frame_end);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = advance_raster(i_tick);
                if (typed_valid)
                    want = typed_word;
                pending_pixels.push_back(want);
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send_tick(input logic tick, input logic typed, input t_pixel_word word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_cfg_we   <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_tick      <= tick;
        i_cfg_we    <= 1'b0;
        typed_valid <= typed;
        typed_word  <= word;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_pixels.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_timing_reg(input t_cfg_idx idx, input logic [23:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_H_PORCH_BEFORE: timing_cfg.h_porch_before = data[9:0];
            CFG_H_ACTIVE:       timing_cfg.h_active       = data[10:0];
            CFG_H_PORCH_AFTER:  timing_cfg.h_porch_after  = data[9:0];
            CFG_V_SYNC_LINES:   timing_cfg.v_sync_lines   = data[5:0];
            CFG_V_PORCH_BEFORE: timing_cfg.v_porch_before = data[7:0];
            CFG_V_ACTIVE:       timing_cfg.v_active       = data[10:0];
            CFG_V_PORCH_AFTER:  timing_cfg.v_porch_after  = data[7:0];
            CFG_FILL_COLOUR:    timing_cfg.fill_colour    = data;
            default: ;
        endcase
    endtask

    task automatic program_timing(input t_cfg c);
        drain_words();
        write_timing_reg(CFG_H_PORCH_BEFORE, 24'(c.h_porch_before));
        write_timing_reg(CFG_H_ACTIVE,       24'(c.h_active));
        write_timing_reg(CFG_H_PORCH_AFTER,  24'(c.h_porch_after));
        write_timing_reg(CFG_V_SYNC_LINES,   24'(c.v_sync_lines));
        write_timing_reg(CFG_V_PORCH_BEFORE, 24'(c.v_porch_before));
        write_timing_reg(CFG_V_ACTIVE,       24'(c.v_active));
        write_timing_reg(CFG_V_PORCH_AFTER,  24'(c.v_porch_after));
        write_timing_reg(CFG_FILL_COLOUR,    c.fill_colour);
    endtask

    // small rasters wrap often; wide ones hit the horizontal register maxima, tall ones most vertical ones
    function automatic t_cfg random_timing(input t_shape shape);
        t_cfg c;
        c.h_porch_before = 10'($urandom_range(0, 3));
        c.h_active       = 11'($urandom_range(0, 4));
        c.h_porch_after  = 10'($urandom_range(0, 3));
        c.v_sync_lines   = 6'($urandom_range(0, 2));
        c.v_porch_before = 8'($urandom_range(0, 2));
        c.v_active       = 11'($urandom_range(0, 4));
        c.v_porch_after  = 8'($urandom_range(0, 2));
        c.fill_colour    = 24'($urandom);
        if (shape == SHAPE_WIDE) begin
            c.h_porch_before = 10'd1023;
            c.h_active       = 11'd2047;
            c.h_porch_after  = 10'd1023;
        end else if (shape == SHAPE_TALL) begin
            c.h_porch_before = 10'd0;
            c.h_active       = 11'd1;
            c.h_porch_after  = 10'd0;
            c.v_sync_lines   = 6'd63;
            c.v_porch_before = 8'd0;
            c.v_active       = 11'd2047;
            c.v_porch_after  = 8'd255;
        end
        return c;
    endfunction

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_shape shape;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                if (i == 0 || directed_rows[i-1].kind != ROW_WRITE)
                    drain_words();
                write_timing_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].word);
            end
        end

        for (int p = 0; p < 8; p++) begin
            shape = (p == 2) ? SHAPE_WIDE : (p == 5) ? SHAPE_TALL : SHAPE_SMALL;
            program_timing(random_timing(shape));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            repeat (180)
                send_tick($urandom_range(0, 7) != 0, 1'b0, NO_WORD);
        end

        // back-pressure: long output hold-off, then a full drain mid-stream
        program_timing(random_timing(SHAPE_SMALL));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 60; k++) begin
            if (k == 5)
                hold_req <= 1'b1;
            else if (k == 6)
                hold_req <= 1'b0;
            if (k == 40)
                drain_words();
            send_tick($urandom_range(0, 7) != 0, 1'b0, NO_WORD);
        end

        drain_words();
        repeat (3) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
